>>> rtl/atrm_pkg.sv
// Shared constants and types for the accelerometer tilt to rotation matrix block.
package atrm_pkg;

    // Default fraction width of the matrix elements (Q1.14).
    localparam int FRAC_BITS_DEF = 14;

    // Width of sample and matrix element fields.
    localparam int DATA_W = 16;

    // Width of the numerator and denominator carried into each lane.
    localparam int NUM_W = 64;

    // Number of matrix elements, and the first lane of each row.
    localparam int NUM_LANES  = 9;
    localparam int LANE_SOUTH = 0;
    localparam int LANE_WEST  = 3;
    localparam int LANE_DOWN  = 6;

    // Cycles spent in the front end before the lanes.
    localparam int FRONT_LAT = 4;

    // Largest element magnitude that fits the output field.
    localparam logic [31:0] OUT_MAX = 32'd32767;

    // Sensor axis codes.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Register indexes.
    localparam logic REG_WEST_AXIS = 1'b0;

    // One element to evaluate: round(sqrt(num / den) * 2^FRAC_BITS), signed by neg.
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] den;
        logic             neg;
    } t_lane;

    typedef t_lane [NUM_LANES-1:0] t_lane_arr;

    // One finished matrix.
    typedef struct packed {
        logic [NUM_LANES-1:0][DATA_W-1:0] val;
        logic                             deg;
    } t_result;

endpackage

>>> rtl/atrm_front.sv
// Front end: squares, vector norms and per-element numerator and denominator.
module atrm_front (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [1:0]                  i_west_axis,
    input  logic signed [15:0]          i_accel_x,
    input  logic signed [15:0]          i_accel_y,
    input  logic signed [15:0]          i_accel_z,
    output atrm_pkg::t_lane_arr         o_lanes,
    output logic                        o_degenerate
);

    // Stage A registers.
    logic signed [15:0] r_a [3];
    logic [1:0]         r_ak;
    // Stage B registers.
    logic [30:0]        r_bsq [3];
    logic [2:0]         r_bneg;
    logic [2:0]         r_bnz;
    logic [1:0]         r_bk;
    // Stage C registers.
    logic [31:0]        r_n;
    logic [31:0]        r_m;
    logic [30:0]        r_csq [3];
    logic [2:0]         r_cneg;
    logic [2:0]         r_cnz;
    logic [1:0]         r_ck;
    // Stage D registers.
    atrm_pkg::t_lane_arr r_lanes;
    logic               r_deg;

    logic signed [31:0] w_sqr [3];
    logic [31:0]        n_n;
    logic [30:0]        w_sqk;
    logic [61:0]        w_pw [3];
    logic [63:0]        w_nm;
    logic [2:0]         w_pos;
    logic [2:0]         w_same;
    atrm_pkg::t_lane_arr n_lanes;

    // Stage A: capture the sample and the west axis, with code 3 falling back to y.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a[0] <= i_accel_x;
            r_a[1] <= i_accel_y;
            r_a[2] <= i_accel_z;
            r_ak   <= (i_west_axis == 2'd3) ? atrm_pkg::AXIS_Y : i_west_axis;
        end
    end

    // Stage B: squares and signs of each axis.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sqr[i] = r_a[i] * r_a[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_bsq[i]  <= w_sqr[i][30:0];
                r_bneg[i] <= r_a[i][15];
                r_bnz[i]  <= (r_a[i] != 16'sd0);
            end
            r_bk <= r_ak;
        end
    end

    // Stage C: squared norm n and squared norm m without the west axis.
    always_comb begin
        n_n = 32'(r_bsq[0]) + 32'(r_bsq[1]) + 32'(r_bsq[2]);
        case (r_bk)
            atrm_pkg::AXIS_X: w_sqk = r_bsq[0];
            atrm_pkg::AXIS_Z: w_sqk = r_bsq[2];
            default:          w_sqk = r_bsq[1];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n    <= n_n;
            r_m    <= n_n - 32'(w_sqk);
            r_csq  <= r_bsq;
            r_cneg <= r_bneg;
            r_cnz  <= r_bnz;
            r_ck   <= r_bk;
        end
    end

    // Stage D: products and the nine lane requests.
    always_comb begin
        logic [30:0] sqk;
        logic        negk;
        case (r_ck)
            atrm_pkg::AXIS_X: begin
                sqk  = r_csq[0];
                negk = r_cneg[0];
            end
            atrm_pkg::AXIS_Z: begin
                sqk  = r_csq[2];
                negk = r_cneg[2];
            end
            default: begin
                sqk  = r_csq[1];
                negk = r_cneg[1];
            end
        endcase
        w_nm = 64'(r_n) * 64'(r_m);
        for (int i = 0; i < 3; i++) begin
            w_pw[i]   = 62'(r_csq[i]) * 62'(sqk);
            w_pos[i]  = r_cnz[i] && !r_cneg[i];
            // Same non-zero sign on this axis and the west axis makes west negative.
            w_same[i] = r_cnz[i] && (w_pw[i] != 62'd0) && (r_cneg[i] == negk);
        end

        for (int i = 0; i < atrm_pkg::NUM_LANES; i++) begin
            n_lanes[i].num = '0;
            n_lanes[i].den = 64'(r_m);
            n_lanes[i].neg = 1'b0;
        end

        // Down row: a_i squared over n.
        for (int i = 0; i < 3; i++) begin
            n_lanes[atrm_pkg::LANE_DOWN+i].num = 64'(r_csq[i]);
            n_lanes[atrm_pkg::LANE_DOWN+i].den = 64'(r_n);
            n_lanes[atrm_pkg::LANE_DOWN+i].neg = r_cneg[i];
        end

        // West row: m over n on the west axis, a_i a_k squared over n m elsewhere.
        for (int i = 0; i < 3; i++) begin
            n_lanes[atrm_pkg::LANE_WEST+i].num = 64'(w_pw[i]);
            n_lanes[atrm_pkg::LANE_WEST+i].den = w_nm;
            n_lanes[atrm_pkg::LANE_WEST+i].neg = w_same[i];
        end

        // South row: the cross product of the west axis with the sample, over m.
        case (r_ck)
            atrm_pkg::AXIS_X: begin
                n_lanes[atrm_pkg::LANE_WEST].num   = 64'(r_m);
                n_lanes[atrm_pkg::LANE_WEST].den   = 64'(r_n);
                n_lanes[atrm_pkg::LANE_WEST].neg   = 1'b0;
                n_lanes[atrm_pkg::LANE_SOUTH+1].num = 64'(r_csq[2]);
                n_lanes[atrm_pkg::LANE_SOUTH+1].neg = w_pos[2];
                n_lanes[atrm_pkg::LANE_SOUTH+2].num = 64'(r_csq[1]);
                n_lanes[atrm_pkg::LANE_SOUTH+2].neg = r_cneg[1];
            end
            atrm_pkg::AXIS_Z: begin
                n_lanes[atrm_pkg::LANE_WEST+2].num = 64'(r_m);
                n_lanes[atrm_pkg::LANE_WEST+2].den = 64'(r_n);
                n_lanes[atrm_pkg::LANE_WEST+2].neg = 1'b0;
                n_lanes[atrm_pkg::LANE_SOUTH].num   = 64'(r_csq[1]);
                n_lanes[atrm_pkg::LANE_SOUTH].neg   = w_pos[1];
                n_lanes[atrm_pkg::LANE_SOUTH+1].num = 64'(r_csq[0]);
                n_lanes[atrm_pkg::LANE_SOUTH+1].neg = r_cneg[0];
            end
            default: begin
                n_lanes[atrm_pkg::LANE_WEST+1].num = 64'(r_m);
                n_lanes[atrm_pkg::LANE_WEST+1].den = 64'(r_n);
                n_lanes[atrm_pkg::LANE_WEST+1].neg = 1'b0;
                n_lanes[atrm_pkg::LANE_SOUTH].num   = 64'(r_csq[2]);
                n_lanes[atrm_pkg::LANE_SOUTH].neg   = r_cneg[2];
                n_lanes[atrm_pkg::LANE_SOUTH+2].num = 64'(r_csq[0]);
                n_lanes[atrm_pkg::LANE_SOUTH+2].neg = w_pos[0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lanes <= n_lanes;
            r_deg   <= (r_m == 32'd0);
        end
    end

    assign o_lanes      = r_lanes;
    assign o_degenerate = r_deg;

endmodule

>>> rtl/atrm_lane.sv
// One matrix element: pipelined divider, pipelined square root, rounding and saturation.
module atrm_lane #(
    parameter int FRAC_BITS = atrm_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  atrm_pkg::t_lane    i_lane,
    output logic signed [15:0] o_value
);

    // Quotient bits, root bits and root remainder width.
    localparam int QW = 2 * FRAC_BITS + 3;
    localparam int SW = FRAC_BITS + 2;
    localparam int TW = QW + 2;
    localparam int NW = atrm_pkg::NUM_W;

    logic [NW-1:0] r_rem [1:QW];
    logic [QW-1:0] r_quo [1:QW];
    logic [NW-1:0] r_den [1:QW];
    logic [SW-1:0] r_s   [1:SW];
    logic [TW-1:0] r_rq  [1:SW];
    logic          r_neg [1:QW+SW];
    logic          r_zero[1:QW+SW];
    logic signed [15:0] r_out;

    // Sign and zero flags travel alongside the arithmetic.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[1]  <= i_lane.neg;
            r_zero[1] <= (i_lane.num == '0);
            for (int j = 2; j <= QW + SW; j++) begin
                r_neg[j]  <= r_neg[j-1];
                r_zero[j] <= r_zero[j-1];
            end
        end
    end

    // Restoring division of num * 2^(2F+2) by den, one quotient bit per stage.
    // The remainder starts at num / 2, which is below den; the low bit of num
    // is shifted in first and zeros after it.
    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [NW-1:0] w_rin;
        logic [QW-1:0] w_qin;
        logic [NW-1:0] w_din;
        logic          w_bit;
        logic [NW-1:0] w_sh;
        logic          w_ge;
        if (j == 0) begin : g_first
            assign w_rin = {1'b0, i_lane.num[NW-1:1]};
            assign w_qin = '0;
            assign w_din = i_lane.den;
            assign w_bit = i_lane.num[0];
        end else begin : g_next
            assign w_rin = r_rem[j];
            assign w_qin = r_quo[j];
            assign w_din = r_den[j];
            assign w_bit = 1'b0;
        end
        assign w_sh = {w_rin[NW-2:0], w_bit};
        assign w_ge = (w_sh >= w_din);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= w_ge ? (w_sh - w_din) : w_sh;
                r_quo[j+1] <= {w_qin[QW-2:0], w_ge};
                r_den[j+1] <= w_din;
            end
        end
    end

    // Integer square root of the quotient, one root bit per stage from the top.
    for (genvar j = 0; j < SW; j++) begin : g_sqrt
        localparam int B = SW - 1 - j;
        logic [SW-1:0] w_sin;
        logic [TW-1:0] w_rqin;
        logic [TW-1:0] w_inc;
        logic          w_ge;
        if (j == 0) begin : g_first
            assign w_sin  = '0;
            assign w_rqin = TW'(r_quo[QW]);
        end else begin : g_next
            assign w_sin  = r_s[j];
            assign w_rqin = r_rq[j];
        end
        assign w_inc = (TW'(w_sin) << (B + 1)) | (TW'(1) << (2 * B));
        assign w_ge  = (w_rqin >= w_inc);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rq[j+1] <= w_ge ? (w_rqin - w_inc) : w_rqin;
                r_s[j+1]  <= w_ge ? (w_sin | (SW'(1) << B)) : w_sin;
            end
        end
    end

    // Largest odd number under the root gives the rounded element; then saturate and sign.
    always_ff @(posedge i_clk) begin
        logic [SW:0]  w_sum;
        logic [31:0]  w_mag;
        logic [15:0]  w_sat;
        if (i_en) begin
            w_sum = {1'b0, r_s[SW]} + (SW+1)'(1);
            w_mag = 32'(w_sum[SW:1]);
            w_sat = (w_mag > atrm_pkg::OUT_MAX) ? atrm_pkg::OUT_MAX[15:0] : w_mag[15:0];
            if (r_zero[QW+SW]) begin
                r_out <= '0;
            end else if (r_neg[QW+SW]) begin
                r_out <= -$signed(w_sat);
            end else begin
                r_out <= $signed(w_sat);
            end
        end
    end

    assign o_value = r_out;

endmodule

>>> rtl/accel_tilt_rotation_matrix.sv
// Top level: accelerometer sample to south, west and down rows of a rotation matrix.
//
//  Channel   Direction  Handshake                       Payload
//  in        to block   i_in_valid / o_in_ready         i_accel_x, i_accel_y, i_accel_z
//  out       from block o_out_valid / i_out_ready       o_south_*, o_west_*, o_down_*,
//                                                       o_degenerate
//  config    to block   i_psel, i_penable, o_pready     i_paddr, i_pwdata, o_prdata
//
// One request is taken per cycle while the output buffer has room. A result passes
// through four front stages, the first loaded at the accepting edge, a divider of
// 2*FRAC_BITS+3 stages, a square root of FRAC_BITS+2 stages, a rounding stage and
// the output buffer.
// Reset is synchronous and active low; it clears valid bits, the buffer and sets
// west_axis to y. The whole pipeline halts only when the two-entry output buffer is full,
// so a waiting result does not stop the next request from entering.
module accel_tilt_rotation_matrix #(
    parameter int FRAC_BITS = atrm_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration port.
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [2:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    output logic [31:0]        o_prdata,
    output logic               o_pready,
    // Sample channel.
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    // Matrix channel.
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_south_x,
    output logic signed [15:0] o_south_y,
    output logic signed [15:0] o_south_z,
    output logic signed [15:0] o_west_x,
    output logic signed [15:0] o_west_y,
    output logic signed [15:0] o_west_z,
    output logic signed [15:0] o_down_x,
    output logic signed [15:0] o_down_y,
    output logic signed [15:0] o_down_z,
    output logic               o_degenerate
);

    localparam int LANE_LAT = (2 * FRAC_BITS + 3) + (FRAC_BITS + 2) + 1;
    localparam int PIPE_LAT = atrm_pkg::FRONT_LAT + LANE_LAT;

    logic [1:0]          r_west_axis;
    logic                r_vld [1:PIPE_LAT];
    logic                r_deg [1:LANE_LAT];
    atrm_pkg::t_result   r_buf [2];
    logic                r_wr;
    logic                r_rd;
    logic [1:0]          r_cnt;

    logic                w_en;
    logic                w_push;
    logic                w_pop;
    atrm_pkg::t_lane_arr w_lanes;
    logic                w_front_deg;
    logic [atrm_pkg::NUM_LANES-1:0][15:0] w_vals;
    atrm_pkg::t_result   w_res;
    atrm_pkg::t_result   w_head;

    // Configuration register write and read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_west_axis <= atrm_pkg::AXIS_Y;
        end else if (i_psel && i_penable && i_pwrite && o_pready
                     && (i_paddr[2] == atrm_pkg::REG_WEST_AXIS)) begin
            r_west_axis <= i_pwdata[1:0];
        end
    end

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == atrm_pkg::REG_WEST_AXIS) ? {30'd0, r_west_axis} : 32'd0;

    // The pipeline advances whenever the output buffer has room.
    assign w_en       = (r_cnt != 2'd2);
    assign o_in_ready = w_en;

    atrm_front u_front (
        .i_clk        (i_clk),
        .i_en         (w_en),
        .i_west_axis  (r_west_axis),
        .i_accel_x    (i_accel_x),
        .i_accel_y    (i_accel_y),
        .i_accel_z    (i_accel_z),
        .o_lanes      (w_lanes),
        .o_degenerate (w_front_deg)
    );

    for (genvar i = 0; i < atrm_pkg::NUM_LANES; i++) begin : g_lane
        atrm_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_lane  (w_lanes[i]),
            .o_value (w_vals[i])
        );
    end

    // Valid bits follow the requests through every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 1; j <= PIPE_LAT; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[1] <= i_in_valid;
            for (int j = 2; j <= PIPE_LAT; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
    end

    // The degenerate flag waits for the lanes.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_deg[1] <= w_front_deg;
            for (int j = 2; j <= LANE_LAT; j++) begin
                r_deg[j] <= r_deg[j-1];
            end
        end
    end

    // Two-entry output buffer.
    assign w_res.val = w_vals;
    assign w_res.deg = r_deg[LANE_LAT];
    assign w_push    = w_en && r_vld[PIPE_LAT];
    assign w_pop     = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    assign w_head       = r_buf[r_rd];
    assign o_out_valid  = (r_cnt != 2'd0);
    assign o_south_x    = w_head.val[atrm_pkg::LANE_SOUTH];
    assign o_south_y    = w_head.val[atrm_pkg::LANE_SOUTH+1];
    assign o_south_z    = w_head.val[atrm_pkg::LANE_SOUTH+2];
    assign o_west_x     = w_head.val[atrm_pkg::LANE_WEST];
    assign o_west_y     = w_head.val[atrm_pkg::LANE_WEST+1];
    assign o_west_z     = w_head.val[atrm_pkg::LANE_WEST+2];
    assign o_down_x     = w_head.val[atrm_pkg::LANE_DOWN];
    assign o_down_y     = w_head.val[atrm_pkg::LANE_DOWN+1];
    assign o_down_z     = w_head.val[atrm_pkg::LANE_DOWN+2];
    assign o_degenerate = w_head.deg;

    // The buffer never holds more than two results.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    // A halted pipeline keeps its last valid bit.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> (r_vld[PIPE_LAT] == $past(r_vld[PIPE_LAT])))
        else $error("pipeline moved while halted");

    // A degenerate sample has no south or west row.
    a_deg_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_degenerate) |-> (o_south_x == 16'sd0 && o_south_y == 16'sd0
            && o_south_z == 16'sd0 && o_west_x == 16'sd0 && o_west_y == 16'sd0
            && o_west_z == 16'sd0))
        else $error("degenerate result with non-zero south or west");

    // A result is pushed only when the buffer has room.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_cnt != 2'd2))
        else $error("result pushed into a full buffer");

endmodule
